/* rtl/rtp_header_parser_macros.svh */
// Assertion macros shared by the parser modules
`ifndef RTP_HEADER_PARSER_MACROS_SVH
`define RTP_HEADER_PARSER_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every edge out of reset
`define RTP_HP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition that must be followed by another in the next cycle
`define RTP_HP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RTP_HP_ASSERT(lbl, clk, rst_n, prop, msg)
`define RTP_HP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/rtp_hp_pkg.sv */
package rtp_hp_pkg;

  localparam int MAX_PACKET_BYTES = 2048;
  localparam int EXT_TABLE_DEPTH  = 16;
  localparam int POS_W            = 12;
  localparam int IDX_W            = $clog2(EXT_TABLE_DEPTH);
  localparam int CNT_W            = $clog2(EXT_TABLE_DEPTH + 1);
  localparam int WALK_W           = 18;

  localparam logic [15:0] PROFILE_ONE_BYTE  = 16'hBEDE;
  localparam logic [15:0] PROFILE_TWO_BYTE  = 16'h1000;
  localparam logic [15:0] PROFILE_TWO_MASK  = 16'hFFF0;
  localparam logic [3:0]  ID_TERMINATE      = 4'd15;
  localparam logic [3:0]  ID_INVALID        = 4'd0;
  localparam logic [1:0]  RTP_VERSION       = 2'd2;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_SHORT    = 4'd1,
    ST_VERSION  = 4'd2,
    ST_CSRC     = 4'd3,
    ST_EXTHDR   = 4'd4,
    ST_EXTDATA  = 4'd5,
    ST_ZEROPAD  = 4'd6,
    ST_PADOVER  = 4'd7,
    ST_TOOLONG  = 4'd8,
    ST_OK_FULL  = 4'd9
  } status_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [11:0] offset;
    logic [7:0]  length;
  } ext_entry_t;

  // one finished packet as handed from the parser to the emitter
  typedef struct packed {
    status_t                          status;
    logic                             marker;
    logic [6:0]                       ptype;
    logic [15:0]                      seq;
    logic [31:0]                      ts;
    logic [31:0]                      ssrc;
    logic [11:0]                      offset;
    logic [11:0]                      plen;
    logic [7:0]                       pad;
    logic [CNT_W-1:0]                 cnt;
    ext_entry_t [EXT_TABLE_DEPTH-1:0] entries;
  } pkt_rec_t;

  typedef struct packed {
    logic        is_extension;
    status_t     status;
    logic        marker_flag;
    logic [6:0]  payload_kind;
    logic [15:0] seq_number;
    logic [31:0] time_stamp;
    logic [31:0] source_id;
    logic [11:0] start_offset;
    logic [11:0] byte_length;
    logic [7:0]  pad_or_id;
    logic        last_result;
  } res_t;

endpackage

/* rtl/rtp_hp_if.sv */
// packet byte channel
interface rtp_hp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_packet;

  modport source (output valid, data_byte, end_of_packet, input ready);
  modport sink (input valid, data_byte, end_of_packet, output ready);
endinterface

// parse result channel
interface rtp_hp_out_if;
  logic        valid;
  logic        ready;
  logic        is_extension;
  logic [3:0]  status;
  logic        marker_flag;
  logic [6:0]  payload_kind;
  logic [15:0] seq_number;
  logic [31:0] time_stamp;
  logic [31:0] source_id;
  logic [11:0] start_offset;
  logic [11:0] byte_length;
  logic [7:0]  pad_or_id;
  logic        last_result;

  modport source (output valid, is_extension, status, marker_flag, payload_kind, seq_number,
                  time_stamp, source_id, start_offset, byte_length, pad_or_id, last_result,
                  input ready);
  modport sink (input valid, is_extension, status, marker_flag, payload_kind, seq_number,
                time_stamp, source_id, start_offset, byte_length, pad_or_id, last_result,
                output ready);
endinterface

/* rtl/rtp_hp_front.sv */
`include "rtp_header_parser_macros.svh"

module rtp_hp_front
  import rtp_hp_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  rtp_hp_in_if.sink     in_ch,
  output logic          push_o,
  output pkt_rec_t      push_rec_o,
  input  logic          full_i
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [7:0]        fhb_r, fhb_nxt;
  logic [55:0]       hf0_r, hf0_nxt;
  logic [31:0]       hf1_r, hf1_nxt;
  logic [15:0]       prof_r, prof_nxt;
  logic [15:0]       words_r, words_nxt;
  logic [WALK_W-1:0] wnext_r, wnext_nxt;
  logic              two_byte_r, two_byte_nxt;
  logic [7:0]        pend_id_r, pend_id_nxt;
  logic              pending_r, pending_nxt;
  logic              stopped_r, stopped_nxt;
  ext_entry_t [EXT_TABLE_DEPTH-1:0] tbl_r, tbl_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ovf_r, ovf_nxt;
  logic              fin_r, fin_nxt;
  logic [7:0]        last_byte_r, last_byte_nxt;

  logic              acc;
  logic              take;
  logic [7:0]        b;
  logic [POS_W-1:0]  hend;
  logic [POS_W-1:0]  wbase;
  logic [WALK_W:0]   cap;
  logic [WALK_W:0]   n19;
  logic [WALK_W:0]   rel19;
  logic              ext_on;
  logic              walk_en;
  logic [15:0]       prof_new;
  logic              rec_en;
  logic [7:0]        rec_id;
  logic [11:0]       rec_off;
  logic [7:0]        rec_len;
  logic [4:0]        len1;
  logic [EXT_TABLE_DEPTH-1:0] hit;

  // summary terms
  logic [POS_W-1:0]  hlen;
  logic [WALK_W:0]   ext_end;
  logic [POS_W-1:0]  po;
  logic [7:0]        pad;
  logic [POS_W:0]    po_pad;
  status_t           st;

  assign in_ch.ready = !fin_r;
  assign acc  = in_ch.valid && in_ch.ready;
  assign take = acc && (pos_r < POS_W'(MAX_PACKET_BYTES));
  assign b    = in_ch.data_byte;

  // extension layout from the captured first byte
  assign hend    = POS_W'(12) + {6'd0, fhb_r[3:0], 2'b00};
  assign wbase   = hend + POS_W'(4);
  assign cap     = {1'b0, words_r, 2'b00};
  assign n19     = {1'b0, wnext_r};
  assign rel19   = (WALK_W + 1)'(pos_r - wbase);
  assign ext_on  = (pos_r >= POS_W'(12)) && fhb_r[4];
  assign walk_en = ext_on && (pos_r >= wbase) &&
                   ((WALK_W + 1)'(pos_r) < (WALK_W + 1)'(wbase) + cap);
  assign prof_new = {prof_r[7:0], b};
  assign len1     = 5'd1 + {1'b0, b[3:0]};

  // id lookup over the stored entries
  always_comb begin
    for (int i = 0; i < EXT_TABLE_DEPTH; i++) begin
      hit[i] = (CNT_W'(i) < cnt_r) && (tbl_r[i].id == rec_id);
    end
  end

  // summary check on the finished packet
  always_comb begin
    hlen    = POS_W'(12) + {6'd0, fhb_r[3:0], 2'b00};
    ext_end = (WALK_W + 1)'(hlen) + (WALK_W + 1)'(4) + cap;
    po      = fhb_r[4] ? ext_end[POS_W-1:0] : hlen;
    pad     = (fhb_r[5] && (po < pos_r)) ? last_byte_r : 8'd0;
    po_pad  = {1'b0, po} + (POS_W + 1)'(pad);
    if (pos_r > POS_W'(MAX_PACKET_BYTES)) begin
      st = ST_TOOLONG;
    end else if (pos_r < POS_W'(12)) begin
      st = ST_SHORT;
    end else if (fhb_r[7:6] != RTP_VERSION) begin
      st = ST_VERSION;
    end else if (pos_r < hlen) begin
      st = ST_CSRC;
    end else if (fhb_r[4] && (hlen + POS_W'(4) > pos_r)) begin
      st = ST_EXTHDR;
    end else if (fhb_r[4] && (ext_end > (WALK_W + 1)'(pos_r))) begin
      st = ST_EXTDATA;
    end else if (fhb_r[5] && (po < pos_r) && (last_byte_r == 8'd0)) begin
      st = ST_ZEROPAD;
    end else if (po_pad > {1'b0, pos_r}) begin
      st = ST_PADOVER;
    end else if (ovf_r) begin
      st = ST_OK_FULL;
    end else begin
      st = ST_OK;
    end
  end

  // record handed to the queue
  always_comb begin
    push_rec_o = '0;
    push_rec_o.status = st;
    if (st == ST_OK || st == ST_OK_FULL) begin
      push_rec_o.marker  = hf0_r[55];
      push_rec_o.ptype   = hf0_r[54:48];
      push_rec_o.seq     = hf0_r[47:32];
      push_rec_o.ts      = hf0_r[31:0];
      push_rec_o.ssrc    = hf1_r;
      push_rec_o.offset  = po;
      push_rec_o.plen    = pos_r - po - POS_W'(pad);
      push_rec_o.pad     = pad;
      push_rec_o.cnt     = cnt_r;
      push_rec_o.entries = tbl_r;
    end
  end

  assign push_o = fin_r && !full_i;

  // byte capture, extension walk and table update
  always_comb begin
    pos_nxt       = pos_r;
    fhb_nxt       = fhb_r;
    hf0_nxt       = hf0_r;
    hf1_nxt       = hf1_r;
    prof_nxt      = prof_r;
    words_nxt     = words_r;
    wnext_nxt     = wnext_r;
    two_byte_nxt  = two_byte_r;
    pend_id_nxt   = pend_id_r;
    pending_nxt   = pending_r;
    stopped_nxt   = stopped_r;
    tbl_nxt       = tbl_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    fin_nxt       = fin_r;
    last_byte_nxt = last_byte_r;
    rec_en        = 1'b0;
    rec_id        = 8'd0;
    rec_off       = 12'd0;
    rec_len       = 8'd0;

    if (acc) begin
      last_byte_nxt = b;
      fin_nxt       = in_ch.end_of_packet;
      pos_nxt       = take ? pos_r + POS_W'(1) : POS_W'(MAX_PACKET_BYTES + 1);
    end

    if (take) begin
      // fixed header
      if (pos_r == POS_W'(0)) begin
        fhb_nxt = b;
      end else if (pos_r < POS_W'(8)) begin
        hf0_nxt = {hf0_r[47:0], b};
      end else if (pos_r < POS_W'(12)) begin
        hf1_nxt = {hf1_r[23:0], b};
      end

      // extension header
      if (ext_on) begin
        if (pos_r == hend || pos_r == hend + POS_W'(1)) begin
          prof_nxt = prof_new;
        end
        if (pos_r == hend + POS_W'(1)) begin
          if (prof_new == PROFILE_ONE_BYTE) begin
            two_byte_nxt = 1'b0;
          end else if ((prof_new & PROFILE_TWO_MASK) == PROFILE_TWO_BYTE) begin
            two_byte_nxt = 1'b1;
          end else begin
            stopped_nxt = 1'b1;
          end
        end
        if (pos_r == hend + POS_W'(2) || pos_r == hend + POS_W'(3)) begin
          words_nxt = {words_r[7:0], b};
        end
      end

      // element walk
      if (walk_en && !stopped_r) begin
        if (pending_r) begin
          if (rel19 == n19 + (WALK_W + 1)'(1)) begin
            pending_nxt = 1'b0;
            if (n19 + (WALK_W + 1)'(2) + (WALK_W + 1)'(b) > cap) begin
              stopped_nxt = 1'b1;
            end else begin
              rec_en    = 1'b1;
              rec_id    = pend_id_r;
              rec_off   = wbase + wnext_r[11:0] + 12'd2;
              rec_len   = b;
              wnext_nxt = wnext_r + WALK_W'(2) + WALK_W'(b);
            end
          end
        end else if (rel19 == n19) begin
          if (!(n19 + (two_byte_r ? (WALK_W + 1)'(2) : (WALK_W + 1)'(1)) < cap)) begin
            stopped_nxt = 1'b1;
          end else if (b == 8'd0) begin
            wnext_nxt = wnext_r + WALK_W'(1);
          end else if (!two_byte_r) begin
            if (b[7:4] == ID_TERMINATE || b[7:4] == ID_INVALID ||
                n19 + (WALK_W + 1)'(1) + (WALK_W + 1)'(len1) > cap) begin
              stopped_nxt = 1'b1;
            end else begin
              rec_en    = 1'b1;
              rec_id    = {4'd0, b[7:4]};
              rec_off   = wbase + wnext_r[11:0] + 12'd1;
              rec_len   = {3'd0, len1};
              wnext_nxt = wnext_r + WALK_W'(1) + WALK_W'(len1);
            end
          end else begin
            pending_nxt = 1'b1;
            pend_id_nxt = b;
          end
        end
      end
    end

    // table write: overwrite on a repeated id, append otherwise, flag overflow when full
    if (rec_en) begin
      if (|hit) begin
        for (int i = 0; i < EXT_TABLE_DEPTH; i++) begin
          if (hit[i]) begin
            tbl_nxt[i].offset = rec_off;
            tbl_nxt[i].length = rec_len;
          end
        end
      end else if (cnt_r < CNT_W'(EXT_TABLE_DEPTH)) begin
        tbl_nxt[cnt_r[IDX_W-1:0]].id     = rec_id;
        tbl_nxt[cnt_r[IDX_W-1:0]].offset = rec_off;
        tbl_nxt[cnt_r[IDX_W-1:0]].length = rec_len;
        cnt_nxt = cnt_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end

    // packet handed off: clear per-packet state
    if (push_o) begin
      pos_nxt      = '0;
      fhb_nxt      = '0;
      hf0_nxt      = '0;
      hf1_nxt      = '0;
      prof_nxt     = '0;
      words_nxt    = '0;
      wnext_nxt    = '0;
      two_byte_nxt = 1'b0;
      pend_id_nxt  = '0;
      pending_nxt  = 1'b0;
      stopped_nxt  = 1'b0;
      cnt_nxt      = '0;
      ovf_nxt      = 1'b0;
      fin_nxt      = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      fhb_r      <= '0;
      prof_r     <= '0;
      words_r    <= '0;
      wnext_r    <= '0;
      two_byte_r <= 1'b0;
      pending_r  <= 1'b0;
      stopped_r  <= 1'b0;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      fin_r      <= 1'b0;
      hf0_r      <= '0;
      hf1_r      <= '0;
    end else begin
      pos_r      <= pos_nxt;
      fhb_r      <= fhb_nxt;
      prof_r     <= prof_nxt;
      words_r    <= words_nxt;
      wnext_r    <= wnext_nxt;
      two_byte_r <= two_byte_nxt;
      pending_r  <= pending_nxt;
      stopped_r  <= stopped_nxt;
      cnt_r      <= cnt_nxt;
      ovf_r      <= ovf_nxt;
      fin_r      <= fin_nxt;
      hf0_r      <= hf0_nxt;
      hf1_r      <= hf1_nxt;
    end
  end

  // payload state
  always_ff @(posedge clk) begin
    pend_id_r   <= pend_id_nxt;
    tbl_r       <= tbl_nxt;
    last_byte_r <= last_byte_nxt;
  end

  `RTP_HP_ASSERT_NEXT(a_eop_finishes, clk, rst_n, acc && in_ch.end_of_packet, fin_r, "last word did not start the summary")
  `RTP_HP_ASSERT_NEXT(a_handoff_clears, clk, rst_n, push_o, pos_r == '0 && cnt_r == '0 && !ovf_r, "packet state not cleared after handoff")

endmodule

/* rtl/rtp_hp_queue.sv */
`include "rtp_header_parser_macros.svh"

module rtp_hp_queue
  import rtp_hp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_i,
  input  pkt_rec_t push_rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output pkt_rec_t head_o,
  output logic     empty_o
);

  pkt_rec_t   mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full_o  = (cnt_r == 2'd2);
  assign empty_o = (cnt_r == 2'd0);
  assign head_o  = mem_r[rp_r];

  // pointer and fill update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push_i) begin
      wp_nxt = !wp_r;
    end
    if (pop_i) begin
      rp_nxt = !rp_r;
    end
    case ({push_i, pop_i})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wp_r] <= push_rec_i;
    end
  end

  `RTP_HP_ASSERT(a_no_overflow, clk, rst_n, !(push_i && full_o), "push into full packet queue")

endmodule

/* rtl/rtp_hp_back.sv */
`include "rtp_header_parser_macros.svh"

module rtp_hp_back
  import rtp_hp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  pkt_rec_t    head_i,
  input  logic        empty_i,
  output logic        pop_o,
  rtp_hp_out_if.source out_ch
);

  pkt_rec_t          cur_r, cur_nxt;
  logic              cur_valid_r, cur_valid_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  res_t              out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;
  res_t              item;
  ext_entry_t        ent;
  logic [CNT_W-1:0]  eidx;
  logic              out_load;

  assign eidx = idx_r - CNT_W'(1);
  assign ent  = cur_r.entries[eidx[IDX_W-1:0]];

  // result word for the current index: summary first, then entries
  always_comb begin
    item = '0;
    item.status = cur_r.status;
    if (idx_r == '0) begin
      item.marker_flag  = cur_r.marker;
      item.payload_kind = cur_r.ptype;
      item.seq_number   = cur_r.seq;
      item.time_stamp   = cur_r.ts;
      item.source_id    = cur_r.ssrc;
      item.start_offset = cur_r.offset;
      item.byte_length  = cur_r.plen;
      item.pad_or_id    = cur_r.pad;
      item.last_result  = (cur_r.cnt == '0);
    end else begin
      item.is_extension = 1'b1;
      item.start_offset = ent.offset;
      item.byte_length  = {4'd0, ent.length};
      item.pad_or_id    = ent.id;
      item.last_result  = (idx_r == cur_r.cnt);
    end
  end

  assign out_load = cur_valid_r && (!out_valid_r || out_ch.ready);

  // sequencing through the packet and loading the next one
  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    pop_o         = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_nxt       = item;
      out_valid_nxt = 1'b1;
      if (item.last_result) begin
        cur_valid_nxt = 1'b0;
        idx_nxt       = '0;
      end else begin
        idx_nxt = idx_r + CNT_W'(1);
      end
    end
    if (!empty_i && !cur_valid_nxt) begin
      pop_o         = 1'b1;
      cur_nxt       = head_i;
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.is_extension = out_r.is_extension;
  assign out_ch.status       = out_r.status;
  assign out_ch.marker_flag  = out_r.marker_flag;
  assign out_ch.payload_kind = out_r.payload_kind;
  assign out_ch.seq_number   = out_r.seq_number;
  assign out_ch.time_stamp   = out_r.time_stamp;
  assign out_ch.source_id    = out_r.source_id;
  assign out_ch.start_offset = out_r.start_offset;
  assign out_ch.byte_length  = out_r.byte_length;
  assign out_ch.pad_or_id    = out_r.pad_or_id;
  assign out_ch.last_result  = out_r.last_result;

  `RTP_HP_ASSERT(a_idx_in_range, clk, rst_n, !cur_valid_r || idx_r <= cur_r.cnt, "entry index past stored count")

endmodule

/* rtl/rtp_header_parser.sv */
// RTP header parser. Packet bytes enter one word per cycle with a last flag while
// input is ready; the parser captures the fixed header, walks one-byte or two-byte
// header extension elements into a 16-entry id table (a repeated id overwrites its
// entry) and after the last byte checks the bounds. Input is held off after the
// last byte for the bounds check and handoff of the packet record into a two-deep
// packet queue, and stalls there while the queue is full. The emitter drains the
// queue one result word per cycle while the receiver is ready: a summary word
// followed by one word per stored extension entry, 1 to 17 words per packet.
module rtp_header_parser
  import rtp_hp_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  rtp_hp_in_if.sink    in_ch,
  rtp_hp_out_if.source out_ch
);

  logic     push;
  logic     full;
  logic     pop;
  logic     empty;
  pkt_rec_t push_rec;
  pkt_rec_t head;

  rtp_hp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_o     (push),
    .push_rec_o (push_rec),
    .full_i     (full)
  );

  rtp_hp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty)
  );

  rtp_hp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule
